### src/cms_pkg.sv
package cms_pkg;

	// Item fields.
	localparam int IDX_W    = 10;
	localparam int MOMENT_W = 16;
	localparam int SPIN_W   = 16;
	localparam int SUM_W    = 48;

	// Cell storage.
	localparam int CELL_COUNT = 1024;
	localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	// A moment times a spin component: 17-bit signed by 16-bit signed.
	localparam int PROD_W = MOMENT_W + SPIN_W + 1;

	// Operation codes.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// One stored cell: sticky saturation flag and three sums.
	typedef struct packed {
		logic saturated;
		sum_t z;
		sum_t y;
		sum_t x;
	} cell_word_t;

	localparam int WORD_W = $bits(cell_word_t);

	// The three products of one atom.
	typedef struct packed {
		prod_t z;
		prod_t y;
		prod_t x;
	} moment_vec_t;

endpackage

### src/cms_in_if.sv
interface cms_in_if;
	import cms_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [1:0]                 operation;
	logic [IDX_W-1:0]           cell_index;
	logic [MOMENT_W-1:0]        moment;
	logic signed [SPIN_W-1:0]   spin_x;
	logic signed [SPIN_W-1:0]   spin_y;
	logic signed [SPIN_W-1:0]   spin_z;
	logic                       last_atom;

	modport source (
		output valid, operation, cell_index, moment, spin_x, spin_y, spin_z, last_atom,
		input  ready
	);

	modport sink (
		input  valid, operation, cell_index, moment, spin_x, spin_y, spin_z, last_atom,
		output ready
	);

endinterface

### src/cms_out_if.sv
interface cms_out_if;
	import cms_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;
	logic signed [SUM_W-1:0] sum_z;
	logic                    saturated;
	logic                    index_error;
	logic                    pass_done;

	modport source (
		output valid, sum_x, sum_y, sum_z, saturated, index_error, pass_done,
		input  ready
	);

	modport sink (
		input  valid, sum_x, sum_y, sum_z, saturated, index_error, pass_done,
		output ready
	);

endinterface

### src/cms_ram.sv
module cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/cms_cell_update.sv
module cms_cell_update
	import cms_pkg::*;
(
	input  cell_word_t  old_word,
	input  moment_vec_t prod,
	output cell_word_t  new_word
);

	logic signed [SUM_W:0] wide_x;
	logic signed [SUM_W:0] wide_y;
	logic signed [SUM_W:0] wide_z;
	logic                  ovf_x;
	logic                  ovf_y;
	logic                  ovf_z;

	// Exact sums one bit wider than the accumulators.
	assign wide_x = {old_word.x[SUM_W-1], old_word.x} + (SUM_W+1)'(prod.x);
	assign wide_y = {old_word.y[SUM_W-1], old_word.y} + (SUM_W+1)'(prod.y);
	assign wide_z = {old_word.z[SUM_W-1], old_word.z} + (SUM_W+1)'(prod.z);

	// Overflow shows as the top two bits of the exact sum differing.
	assign ovf_x = wide_x[SUM_W] ^ wide_x[SUM_W-1];
	assign ovf_y = wide_y[SUM_W] ^ wide_y[SUM_W-1];
	assign ovf_z = wide_z[SUM_W] ^ wide_z[SUM_W-1];

	// Clamp to the bound on the side of the true sign.
	always_comb begin
		new_word.x = ovf_x ? {wide_x[SUM_W], {(SUM_W-1){~wide_x[SUM_W]}}}
		                   : wide_x[SUM_W-1:0];
		new_word.y = ovf_y ? {wide_y[SUM_W], {(SUM_W-1){~wide_y[SUM_W]}}}
		                   : wide_y[SUM_W-1:0];
		new_word.z = ovf_z ? {wide_z[SUM_W], {(SUM_W-1){~wide_z[SUM_W]}}}
		                   : wide_z[SUM_W-1:0];
		new_word.saturated = old_word.saturated | ovf_x | ovf_y | ovf_z;
	end

endmodule

### src/cell_moment_scatter_accumulator.sv
// Accumulates per-cell magnetization sums in one cell memory (flag plus three 48-bit
// sums per cell). Each request is registered into the update stage; a read, and an add
// with the last atom or a bad index, answers through an output register. Adds stream
// at one per cycle unless the stage stalls, even on the same cell: the memory read
// is registered and the previous add's write is forwarded. A clear request, and the
// first state after reset, zeroes all CELL_COUNT (1024) cells in a sweep, one cell per
// cycle, while no request is taken. A waiting result stalls an update stage that holds a result.
module cell_moment_scatter_accumulator
	import cms_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	cms_in_if.sink    item,
	cms_out_if.source result
);

	// Clearing sweep.
	logic               sweep_q;
	logic [CELL_AW-1:0] sweep_cnt_q;

	// Update stage.
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [CELL_AW-1:0] addr_s1;
	logic               err_s1;
	logic               last_s1;
	moment_vec_t        prod_s1;

	// Forwarding of the latest write.
	logic               fwd_valid_q;
	logic [CELL_AW-1:0] fwd_addr_q;
	cell_word_t         fwd_word_q;

	// Output register.
	logic               res_valid_q;
	cell_word_t         res_word_q;
	logic               res_err_q;
	logic               res_done_q;

	logic               accept;
	logic               idx_err;
	logic               has_result_s1;
	logic               fire_s1;
	logic               write_s1;
	cell_word_t         rd_word;
	cell_word_t         old_word;
	cell_word_t         new_word;
	cell_word_t         res_word;
	moment_vec_t        prod;
	logic               ram_we;
	logic [CELL_AW-1:0] ram_waddr;
	cell_word_t         ram_wdata;

	assign idx_err = {1'b0, item.cell_index} >= (IDX_W+1)'(CELL_COUNT);

	// A clear waiting in the update stage blocks new requests until its sweep is done.
	assign has_result_s1 = (op_s1 == OP_READ) || (op_s1 == OP_ADD && (last_s1 || err_s1));
	assign fire_s1 = valid_s1 && (!has_result_s1 || !res_valid_q || result.ready);
	assign item.ready = !sweep_q && !(valid_s1 && op_s1 == OP_CLEAR)
		&& (!valid_s1 || fire_s1);
	assign accept = item.valid && item.ready;

	// Products, registered before the add.
	always_comb begin
		prod.x = $signed({1'b0, item.moment}) * item.spin_x;
		prod.y = $signed({1'b0, item.moment}) * item.spin_y;
		prod.z = $signed({1'b0, item.moment}) * item.spin_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= item.operation;
			addr_s1 <= CELL_AW'(item.cell_index);
			err_s1  <= idx_err;
			last_s1 <= item.last_atom;
			prod_s1 <= prod;
		end
	end

	// Read the cell at acceptance; take the latest write if it hit the same cell.
	assign old_word = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_word_q : rd_word;

	cms_cell_update u_update (
		.old_word (old_word),
		.prod     (prod_s1),
		.new_word (new_word)
	);

	assign write_s1 = fire_s1 && op_s1 == OP_ADD && !err_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (sweep_q) begin
			fwd_valid_q <= 1'b0;
		end else if (write_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (write_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_word_q <= new_word;
		end
	end

	// Sweep runs after reset and after each clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweep_q) begin
			sweep_cnt_q <= sweep_cnt_q + 1'b1;
			if (sweep_cnt_q == CELL_AW'(CELL_COUNT - 1)) begin
				sweep_q <= 1'b0;
			end
		end else if (fire_s1 && op_s1 == OP_CLEAR) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
		end
	end

	// Memory write port serves the sweep or the update stage.
	assign ram_we    = sweep_q || write_s1;
	assign ram_waddr = sweep_q ? sweep_cnt_q : addr_s1;
	assign ram_wdata = sweep_q ? cell_word_t'('0) : new_word;

	cms_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CELL_COUNT)
	) u_cell_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (CELL_AW'(item.cell_index)),
		.rdata (rd_word)
	);

	// Result of the update stage.
	always_comb begin
		if (err_s1) begin
			res_word = '0;
		end else if (op_s1 == OP_ADD) begin
			res_word = new_word;
		end else begin
			res_word = old_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && has_result_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_result_s1) begin
			res_word_q <= res_word;
			res_err_q  <= err_s1;
			res_done_q <= (op_s1 == OP_ADD) && last_s1;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.sum_x       = res_word_q.x;
	assign result.sum_y       = res_word_q.y;
	assign result.sum_z       = res_word_q.z;
	assign result.saturated   = res_word_q.saturated;
	assign result.index_error = res_err_q;
	assign result.pass_done   = res_done_q;

	// A clear leaving the update stage starts the sweep.
	a_clear_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && op_s1 == OP_CLEAR) |=> sweep_q)
		else $error("clear did not start the sweep");

	// The sweep never shares the write port with an update.
	a_sweep_alone: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !valid_s1)
		else $error("update stage busy during sweep");

	// A new result appears only after the update stage produced one.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(fire_s1 && has_result_s1))
		else $error("result without an update stage source");

endmodule
